@@ src/pts_pkg.sv @@
// Package for the priority thread scheduler: status codes, event kinds,
// sequencer states and register addresses. No dependencies.
`default_nettype none
package pts_pkg;
  localparam int unsigned PrioW = 5;
  localparam int unsigned IdW = 32;
  localparam logic [PrioW-1:0] BootPrioReset = 5'd16;

  typedef enum logic [2:0] {
    ST_FREE      = 3'd0,
    ST_READY     = 3'd1,
    ST_RUNNING   = 3'd2,
    ST_SLEEPING  = 3'd3,
    ST_SUSPENDED = 3'd4,
    ST_DEAD      = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    K_CREATE   = 4'd0,
    K_RESUME   = 4'd1,
    K_SUSPEND  = 4'd2,
    K_SLEEP    = 4'd3,
    K_WAKE     = 4'd4,
    K_WAKE_NP  = 4'd5,
    K_EXIT     = 4'd6,
    K_RESCHED  = 4'd7,
    K_YIELD    = 4'd8
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BOOT,
    S_SCAN,
    S_SCAN_WB,
    S_ACT,
    S_CUR_RD,
    S_CUR_WB,
    S_PICK,
    S_PICK_WB,
    S_DONE
  } state_e;

  typedef struct packed {
    logic    used;
    status_e status;
    logic [PrioW-1:0] prio;
    logic [IdW-1:0] thread;
    logic [IdW-1:0] queue;
  } entry_t;

  localparam logic [0:0] AddrBootId = 1'b0;
  localparam logic [0:0] AddrBootPrio = 1'b1;
endpackage
`default_nettype wire

@@ src/pts_table.sv @@
// Slot table memory: one synchronous read port with registered data, one
// write port. Depends on pts_pkg for the entry type.
`default_nettype none
module pts_table #(
  parameter int unsigned Slots = 32,
  parameter int unsigned AW = 5
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output pts_pkg::entry_t rd_data_o,
  input  wire logic we_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  pts_pkg::entry_t wr_data_i
);
  import pts_pkg::*;

  logic [Slots-1:0] used_q;
  logic [$bits(entry_t)-2:0] mem_q [Slots];
  logic [$bits(entry_t)-2:0] rd_q;
  logic rd_used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      rd_used_q <= 1'b0;
    end else begin
      if (we_i) used_q[wr_addr_i] <= wr_data_i.used;
      if (rd_en_i) rd_used_q <= used_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[wr_addr_i] <= wr_data_i[$bits(entry_t)-2:0];
    if (rd_en_i) rd_q <= mem_q[rd_addr_i];
  end

  always_comb begin
    rd_data_o = {rd_used_q, rd_q};
    if (!rd_used_q) rd_data_o.status = ST_FREE;
  end
endmodule
`default_nettype wire

@@ src/priority_thread_scheduler.sv @@
// Priority thread scheduler top level: APB registers, event sequencer and
// slot table. Depends on pts_pkg and pts_table.
// A wake scans each slot with a read and a write-back, a pick scans each slot
// once (one table port). One request at a time; busy_o drops in the result
// cycle and the receiver cannot stall. Reset: asynchronous, clears table valid
// bits, registers and sequencer.
`default_nettype none
module priority_thread_scheduler #(
  parameter int unsigned SLOTS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output logic busy_o,
  input  wire logic [3:0] kind_i,
  input  wire logic [31:0] thread_id_i,
  input  wire logic [31:0] queue_id_i,
  input  wire logic [4:0] new_priority_i,
  output logic done_o,
  output logic ok_o,
  output logic [4:0] running_slot_o,
  output logic [31:0] running_thread_o,
  output logic switched_o,
  output logic idle_o,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import pts_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);
  localparam logic [AW:0] LastSlot = (AW+1)'(SLOTS - 1);

  logic [31:0] boot_id_q;
  logic [4:0] boot_prio_q;
  state_e state_q, state_d;
  logic [3:0] kind_q;
  logic [31:0] tid_q, qid_q;
  logic [4:0] nprio_q;
  logic started_q, idle_q;
  logic [AW-1:0] cur_q;
  logic [AW:0] idx_q, idx_d;
  logic found_q, higher_q, ok_q, sw_q, pre_q;
  logic [AW-1:0] hit_q, best_q;
  logic best_v_q;
  logic [4:0] best_p_q, cur_p_q;
  entry_t cur_e_q;

  logic rd_en, we;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t rd_data, wr_data;
  logic [AW-1:0] idx_a;

  assign idx_a = idx_q[AW-1:0];
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      AddrBootId:   prdata = boot_id_q;
      AddrBootPrio: prdata = {27'd0, boot_prio_q};
      default:      prdata = '0;
    endcase
  end

  pts_table #(.Slots(SLOTS), .AW(AW)) u_table (
    .clk_i, .rst_ni, .rd_en_i(rd_en), .rd_addr_i(rd_addr), .rd_data_o(rd_data),
    .we_i(we), .wr_addr_i(wr_addr), .wr_data_i(wr_data)
  );

  logic accept;
  assign accept = start_i && !busy_o;
  assign busy_o = state_q != S_IDLE;

  logic runnable;
  assign runnable = rd_data.used &&
    (rd_data.status == ST_READY || rd_data.status == ST_RUNNING);
  logic last;
  assign last = idx_q == LastSlot;
  logic scan_kind;
  assign scan_kind = kind_q == K_CREATE || kind_q == K_RESUME ||
    kind_q == K_SUSPEND || kind_q == K_WAKE || kind_q == K_WAKE_NP;
  logic needs_pick;
  assign needs_pick = kind_q == K_SLEEP || kind_q == K_EXIT ||
    kind_q == K_RESCHED || kind_q == K_YIELD ||
    (kind_q == K_SUSPEND && found_q && hit_q == cur_q) || pre_q;

  logic pick_active;
  logic pick_cmp_v_q;
  logic [AW-1:0] pick_cmp_i_q;
  logic cur_run;
  logic [4:0] pick_p;
  logic pick_take;
  assign cur_run = cur_e_q.used &&
    (cur_e_q.status == ST_READY || cur_e_q.status == ST_RUNNING);
  assign pick_p = (pick_cmp_i_q == cur_q) ? cur_e_q.prio : rd_data.prio;
  assign pick_take = pick_cmp_v_q && (pick_cmp_i_q == cur_q ? cur_run : runnable) &&
    (!best_v_q || pick_p < best_p_q);

  // next state
  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    case (state_q)
      S_IDLE: if (accept) state_d = started_q ? S_CUR_RD : S_BOOT;
      S_BOOT: state_d = S_CUR_RD;
      S_CUR_RD: begin
        state_d = S_SCAN;
        idx_d = '0;
      end
      S_SCAN: state_d = S_SCAN_WB;
      S_SCAN_WB: begin
        if (last || (kind_q == K_CREATE && found_q) ||
            ((kind_q == K_RESUME || kind_q == K_SUSPEND) && found_q)) begin
          state_d = S_ACT;
        end else begin
          state_d = S_SCAN;
          idx_d = idx_q + 1'b1;
        end
        if (!scan_kind) state_d = S_ACT;
      end
      S_ACT: state_d = S_CUR_WB;
      S_CUR_WB: begin
        state_d = (needs_pick || idle_q) ? S_PICK : S_DONE;
        idx_d = '0;
      end
      S_PICK: begin
        if (last) state_d = S_PICK_WB;
        idx_d = idx_q + 1'b1;
      end
      S_PICK_WB: state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // table access
  always_comb begin
    rd_en = 1'b0;
    rd_addr = idx_a;
    we = 1'b0;
    wr_addr = cur_q;
    wr_data = cur_e_q;
    case (state_q)
      S_BOOT: begin
        we = 1'b1;
        wr_addr = '0;
        wr_data = '{used: 1'b1, status: ST_RUNNING, prio: boot_prio_q,
                    thread: boot_id_q, queue: '0};
      end
      S_CUR_RD: begin
        rd_en = 1'b1;
        rd_addr = cur_q;
      end
      S_SCAN: rd_en = 1'b1;
      S_SCAN_WB: begin
        wr_addr = idx_a;
        wr_data = rd_data;
        if ((kind_q == K_WAKE || kind_q == K_WAKE_NP) && rd_data.used &&
            rd_data.status == ST_SLEEPING && rd_data.queue == qid_q &&
            idx_a != cur_q) begin
          we = 1'b1;
          wr_data.status = ST_READY;
          wr_data.queue = '0;
        end
      end
      S_ACT: begin
        wr_addr = hit_q;
        if (kind_q == K_CREATE && found_q) begin
          we = 1'b1;
          wr_data = '{used: 1'b1, status: ST_SUSPENDED, prio: nprio_q,
                      thread: tid_q, queue: '0};
        end else if (kind_q == K_RESUME && found_q && hit_q != cur_q) begin
          rd_en = 1'b1;
          rd_addr = hit_q;
        end else if (kind_q == K_SUSPEND && found_q && hit_q != cur_q) begin
          rd_en = 1'b1;
          rd_addr = hit_q;
        end
      end
      S_CUR_WB: begin
        if (kind_q == K_RESUME && found_q && hit_q != cur_q) begin
          we = 1'b1;
          wr_addr = hit_q;
          wr_data = rd_data;
          if (rd_data.status == ST_SUSPENDED) wr_data.status = ST_READY;
        end else if (kind_q == K_SUSPEND && found_q && hit_q != cur_q) begin
          we = 1'b1;
          wr_addr = hit_q;
          wr_data = rd_data;
          wr_data.status = ST_SUSPENDED;
        end
      end
      S_PICK: begin
        if (idx_q == '0) begin
          we = 1'b1;
          wr_addr = cur_q;
          wr_data = cur_e_q;
        end else begin
          rd_en = 1'b0;
        end
        rd_en = 1'b1;
        rd_addr = idx_a;
      end
      S_PICK_WB: begin
        if (best_v_q || pick_take) begin
          rd_en = 1'b1;
          rd_addr = pick_take ? pick_cmp_i_q : best_q;
        end
      end
      S_DONE: begin
        if (best_v_q && pick_active) begin
          we = 1'b1;
          wr_addr = best_q;
          wr_data = rd_data;
          wr_data.status = ST_RUNNING;
        end
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q <= '0;
      boot_id_q <= '0;
      boot_prio_q <= BootPrioReset;
      started_q <= 1'b0;
      idle_q <= 1'b0;
      cur_q <= '0;
      found_q <= 1'b0;
      higher_q <= 1'b0;
      ok_q <= 1'b0;
      sw_q <= 1'b0;
      pre_q <= 1'b0;
      hit_q <= '0;
      best_q <= '0;
      best_p_q <= '0;
      best_v_q <= 1'b0;
      cur_e_q <= '0;
      cur_p_q <= '0;
      pick_active <= 1'b0;
      pick_cmp_v_q <= 1'b0;
      pick_cmp_i_q <= '0;
      done_o <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      done_o <= 1'b0;
      if (psel && penable && pwrite) begin
        if (paddr[2] == AddrBootId) boot_id_q <= pwdata;
        else boot_prio_q <= pwdata[4:0];
      end
      case (state_q)
        S_IDLE: if (accept) begin
          found_q <= 1'b0;
          higher_q <= 1'b0;
          sw_q <= 1'b0;
          pre_q <= 1'b0;
          best_v_q <= 1'b0;
          pick_active <= 1'b0;
          pick_cmp_v_q <= 1'b0;
        end
        S_BOOT: begin
          started_q <= 1'b1;
          cur_q <= '0;
          idle_q <= 1'b0;
        end
        S_SCAN: begin
          if (idx_q == '0) begin
            cur_e_q <= rd_data;
            cur_p_q <= rd_data.prio;
          end
        end
        S_SCAN_WB: begin
          if (kind_q == K_CREATE && !found_q && idx_q != '0 && !rd_data.used) begin
            found_q <= 1'b1;
            hit_q <= idx_a;
          end
          if ((kind_q == K_RESUME || kind_q == K_SUSPEND) && !found_q &&
              rd_data.used && rd_data.thread == tid_q) begin
            found_q <= 1'b1;
            hit_q <= idx_a;
            if (rd_data.prio < cur_p_q) higher_q <= 1'b1;
          end
          if ((kind_q == K_WAKE || kind_q == K_WAKE_NP) && rd_data.used &&
              rd_data.status == ST_SLEEPING && rd_data.queue == qid_q) begin
            if (rd_data.prio < cur_p_q) higher_q <= 1'b1;
            if (idx_a == cur_q) begin
              cur_e_q.status <= ST_READY;
              cur_e_q.queue <= '0;
            end
          end
        end
        S_ACT: begin
          ok_q <= !(kind_q == K_CREATE && !found_q);
          case (kind_q)
            K_RESUME: if (found_q) begin
              if (hit_q == cur_q && cur_e_q.status == ST_SUSPENDED)
                cur_e_q.status <= ST_READY;
              if (higher_q && !idle_q) begin
                pre_q <= 1'b1;
                if ((hit_q == cur_q ? (cur_e_q.status == ST_RUNNING) :
                     (cur_e_q.status == ST_RUNNING)))
                  cur_e_q.status <= ST_READY;
              end
            end
            K_SUSPEND: if (found_q && hit_q == cur_q) cur_e_q.status <= ST_SUSPENDED;
            K_WAKE: if (higher_q && !idle_q) begin
              pre_q <= 1'b1;
              if (cur_e_q.status == ST_RUNNING) cur_e_q.status <= ST_READY;
            end
            K_SLEEP: begin
              cur_e_q.status <= ST_SLEEPING;
              cur_e_q.queue <= qid_q;
            end
            K_EXIT: cur_e_q.status <= ST_DEAD;
            K_RESCHED, K_YIELD:
              if (cur_e_q.status == ST_RUNNING) cur_e_q.status <= ST_READY;
            default: ;
          endcase
        end
        S_CUR_WB: begin
          pick_active <= needs_pick || idle_q;
          best_v_q <= 1'b0;
        end
        S_PICK: begin
          pick_cmp_v_q <= 1'b1;
          pick_cmp_i_q <= idx_a;
          if (pick_cmp_v_q) begin
            if (pick_cmp_i_q == cur_q ? cur_run : runnable) begin
              if (!best_v_q || pick_p < best_p_q) begin
                best_v_q <= 1'b1;
                best_q <= pick_cmp_i_q;
                best_p_q <= pick_p;
              end
            end
          end
        end
        S_PICK_WB: begin
          pick_cmp_v_q <= 1'b0;
          if (pick_cmp_v_q && (pick_cmp_i_q == cur_q ? cur_run : runnable) &&
              (!best_v_q || pick_p < best_p_q)) begin
            best_v_q <= 1'b1;
            best_q <= pick_cmp_i_q;
            best_p_q <= pick_p;
          end
        end
        S_DONE: begin
          done_o <= 1'b1;
          if (pick_active) begin
            idle_q <= !best_v_q;
            if (best_v_q) begin
              sw_q <= sw_q | (best_q != cur_q);
              cur_q <= best_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload captures
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      tid_q <= thread_id_i;
      qid_q <= queue_id_i;
      nprio_q <= new_priority_i;
    end
  end

  // result
  always_comb begin
    ok_o = ok_q;
    switched_o = sw_q;
    idle_o = idle_q;
    running_slot_o = 5'(cur_q);
    running_thread_o = cur_e_q.thread;
    if (pick_active && best_v_q) begin
      idle_o = 1'b0;
      running_slot_o = 5'(best_q);
      running_thread_o = rd_data.thread;
      switched_o = sw_q | (best_q != cur_q);
    end else if (pick_active) begin
      idle_o = 1'b1;
    end
  end

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result without request");
  a_no_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !(state_q == S_BOOT && $past(state_q) != S_IDLE))
    else $error("boot outside accept");
  a_idle_sw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && idle_o) |-> !(switched_o && !$past(sw_q)))
    else $error("switch while idle");
endmodule
`default_nettype wire

@@ tb/priority_thread_scheduler_test.sv @@
// Self-checking testbench for priority_thread_scheduler: directed table of
// events, then random event streams checked against a built-in scheduler model.
// Depends on pts_pkg and the priority_thread_scheduler RTL.
`timescale 1ns / 1ps
module priority_thread_scheduler_test;
  import pts_pkg::*;

  typedef struct {
    logic        ok;
    logic [4:0]  slot;
    logic [31:0] thread;
    logic        sw;
    logic        idle;
  } sched_result_t;

  typedef struct {
    logic [3:0]    kind;
    logic [31:0]   tid;
    logic [31:0]   qid;
    logic [4:0]    prio;
    bit            typed;
    sched_result_t res;
  } event_row_t;

  localparam int NSLOT = 32;
  localparam logic [31:0] RetraceQ = 32'hFFFF_FF01;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [3:0] kind_i = '0;
  logic [31:0] thread_id_i = '0;
  logic [31:0] queue_id_i = '0;
  logic [4:0] new_priority_i = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic busy_o, done_o, ok_o, switched_o, idle_o, pready;
  logic [4:0] running_slot_o;
  logic [31:0] running_thread_o, prdata;

  priority_thread_scheduler dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .kind_i, .thread_id_i, .queue_id_i,
    .new_priority_i, .done_o, .ok_o, .running_slot_o, .running_thread_o,
    .switched_o, .idle_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .pready
  );

  always #5 clk_i = ~clk_i;

  // scheduler model state
  logic [31:0] cfg_boot_id = '0;
  logic [4:0]  cfg_boot_prio = BootPrioReset;
  bit          m_used [NSLOT];
  status_e     m_status [NSLOT];
  logic [4:0]  m_prio [NSLOT];
  logic [31:0] m_thread [NSLOT];
  logic [31:0] m_queue [NSLOT];
  logic [4:0]  m_cur = '0;
  bit          m_idle = 0;
  bit          m_booted = 0;

  sched_result_t pending_results[$];
  int errors = 0;
  int n_requests = 0;
  int n_results = 0;

  function automatic int best_runnable();
    int best = -1;
    for (int k = 0; k < NSLOT; k++) begin
      if (!m_used[k] || !(m_status[k] inside {ST_READY, ST_RUNNING})) continue;
      if (best < 0 || m_prio[k] < m_prio[best]) best = k;
    end
    return best;
  endfunction

  function automatic bit dispatch_next();
    int nxt = best_runnable();
    if (nxt < 0) begin
      m_idle = 1;
      return 0;
    end
    m_idle = 0;
    if (nxt == m_cur) begin
      if (m_status[nxt] == ST_READY) m_status[nxt] = ST_RUNNING;
      return 0;
    end
    m_cur = nxt[4:0];
    m_status[nxt] = ST_RUNNING;
    return 1;
  endfunction

  function automatic bit preempt_current();
    if (m_status[m_cur] == ST_RUNNING) m_status[m_cur] = ST_READY;
    return dispatch_next();
  endfunction

  function automatic int slot_of(logic [31:0] id);
    for (int k = 0; k < NSLOT; k++)
      if (m_used[k] && m_thread[k] == id) return k;
    return -1;
  endfunction

  function automatic sched_result_t schedule_event(event_row_t e);
    sched_result_t r;
    bit ok = 1, sw = 0, higher = 0;
    int k = -1;
    if (!m_booted) begin
      m_used[0] = 1;
      m_status[0] = ST_RUNNING;
      m_prio[0] = cfg_boot_prio;
      m_thread[0] = cfg_boot_id;
      m_queue[0] = '0;
      m_cur = '0;
      m_idle = 0;
      m_booted = 1;
    end
    case (e.kind)
      K_CREATE: begin
        for (int s = 1; s < NSLOT; s++)
          if (!m_used[s]) begin
            k = s;
            break;
          end
        if (k < 0) ok = 0;
        else begin
          m_used[k] = 1;
          m_thread[k] = e.tid;
          m_prio[k] = e.prio;
          m_queue[k] = '0;
          m_status[k] = ST_SUSPENDED;
        end
      end
      K_RESUME: begin
        k = slot_of(e.tid);
        if (k >= 0) begin
          if (m_status[k] == ST_SUSPENDED) m_status[k] = ST_READY;
          if (m_prio[k] < m_prio[m_cur] && !m_idle) sw |= preempt_current();
        end
      end
      K_SUSPEND: begin
        k = slot_of(e.tid);
        if (k >= 0) begin
          m_status[k] = ST_SUSPENDED;
          if (k == m_cur) sw |= dispatch_next();
        end
      end
      K_SLEEP: begin
        m_queue[m_cur] = e.qid;
        m_status[m_cur] = ST_SLEEPING;
        sw |= dispatch_next();
      end
      K_WAKE, K_WAKE_NP: begin
        for (int s = 0; s < NSLOT; s++) begin
          if (!m_used[s] || m_status[s] != ST_SLEEPING || m_queue[s] != e.qid) continue;
          m_status[s] = ST_READY;
          m_queue[s] = '0;
          if (m_prio[s] < m_prio[m_cur]) higher = 1;
        end
        if (e.kind == K_WAKE && higher && !m_idle) sw |= preempt_current();
      end
      K_EXIT: begin
        m_status[m_cur] = ST_DEAD;
        sw |= dispatch_next();
      end
      K_RESCHED, K_YIELD: sw |= preempt_current();
      default: ;
    endcase
    if (m_idle) sw |= dispatch_next();
    r.ok = ok;
    r.slot = m_cur;
    r.thread = m_thread[m_cur];
    r.sw = sw;
    r.idle = m_idle;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, 32'd0);
      end else begin
        sched_result_t w;
        w = pending_results.pop_front();
        n_results++;
        if (ok_o !== w.ok) report_mismatch("ok", 32'(ok_o), 32'(w.ok));
        if (running_slot_o !== w.slot)
          report_mismatch("running_slot", 32'(running_slot_o), 32'(w.slot));
        if (running_thread_o !== w.thread)
          report_mismatch("running_thread", running_thread_o, w.thread);
        if (switched_o !== w.sw) report_mismatch("switched", 32'(switched_o), 32'(w.sw));
        if (idle_o !== w.idle) report_mismatch("idle", 32'(idle_o), 32'(w.idle));
      end
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_check(logic [2:0] addr, logic [31:0] want, logic [31:0] mask);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & mask) !== (want & mask)) report_mismatch("register read", prdata, want);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_boot(logic [31:0] id, logic [4:0] prio);
    apb_write({AddrBootId, 2'b00}, id);
    apb_write({AddrBootPrio, 2'b00}, {27'd0, prio});
    cfg_boot_id = id;
    cfg_boot_prio = prio;
    apb_check({AddrBootId, 2'b00}, id, 32'hFFFF_FFFF);
    apb_check({AddrBootPrio, 2'b00}, {27'd0, prio}, 32'h1F);
  endtask

  task automatic drain();
    while (pending_results.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  task automatic issue(event_row_t e, bit quiet);
    sched_result_t r;
    int gap;
    @(posedge clk_i);
    start_i <= 1'b1;
    kind_i <= e.kind;
    thread_id_i <= e.tid;
    queue_id_i <= e.qid;
    new_priority_i <= e.prio;
    do @(posedge clk_i); while (busy_o);
    r = schedule_event(e);
    pending_results.push_back(e.typed ? e.res : r);
    n_requests++;
    start_i <= 1'b0;
    if (!quiet) begin
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(5, 60);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_tid();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      2: return cfg_boot_id;
      default: return $urandom_range(0, 7);
    endcase
  endfunction

  function automatic logic [31:0] pick_qid();
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2, 3: return RetraceQ;
      default: return $urandom_range(0, 2);
    endcase
  endfunction

  function automatic event_row_t random_event();
    event_row_t e;
    int p = $urandom_range(0, 99);
    e.typed = 0;
    e.res = '{default: '0};
    if (p < 12) e.kind = K_CREATE;
    else if (p < 27) e.kind = K_RESUME;
    else if (p < 37) e.kind = K_SUSPEND;
    else if (p < 50) e.kind = K_SLEEP;
    else if (p < 62) e.kind = K_WAKE;
    else if (p < 70) e.kind = K_WAKE_NP;
    else if (p < 75) e.kind = K_EXIT;
    else if (p < 85) e.kind = K_RESCHED;
    else if (p < 96) e.kind = K_YIELD;
    else e.kind = 4'($urandom_range(9, 15));
    e.tid = pick_tid();
    e.qid = pick_qid();
    e.prio = 5'($urandom_range(0, 31));
    return e;
  endfunction

  event_row_t directed_rows[] = '{
    '{K_YIELD,   32'd0, 32'd0, 5'd0, 1, '{1'b1, 5'd0, 32'hFFFF_FFFF, 1'b0, 1'b0}},
    '{K_CREATE,  32'd0, 32'd0, 5'd0, 1, '{1'b1, 5'd0, 32'hFFFF_FFFF, 1'b0, 1'b0}},
    '{K_CREATE,  32'hFFFF_FFFF, 32'd0, 5'd31, 1,
      '{1'b1, 5'd0, 32'hFFFF_FFFF, 1'b0, 1'b0}},
    '{K_CREATE,  32'h5, 32'hFFFF_FFFF, 5'd31, 0, '{default: '0}},
    '{K_RESUME,  32'd0, 32'd0, 5'd0, 0, '{default: '0}},
    '{K_RESUME,  32'hFFFF_FFFF, 32'd0, 5'd0, 0, '{default: '0}},
    '{K_SUSPEND, 32'h1234_5678, 32'd0, 5'd0, 0, '{default: '0}},
    '{K_SLEEP,   32'd0, RetraceQ, 5'd0, 0, '{default: '0}},
    '{K_WAKE_NP, 32'd0, RetraceQ, 5'd0, 0, '{default: '0}},
    '{K_SLEEP,   32'd0, 32'hFFFF_FFFF, 5'd0, 0, '{default: '0}},
    '{K_WAKE,    32'd0, 32'hFFFF_FFFF, 5'd0, 0, '{default: '0}},
    '{K_RESUME,  32'h5, 32'd0, 5'd0, 0, '{default: '0}},
    '{K_RESCHED, 32'd0, 32'd0, 5'd0, 0, '{default: '0}},
    '{4'd15,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 0, '{default: '0}},
    '{K_EXIT,    32'd0, 32'd0, 5'd0, 0, '{default: '0}},
    '{K_SUSPEND, 32'hFFFF_FFFF, 32'd0, 5'd0, 0, '{default: '0}},
    '{K_SUSPEND, 32'h5, 32'd0, 5'd0, 0, '{default: '0}},
    '{K_SLEEP,   32'd0, 32'd7, 5'd0, 0, '{default: '0}},
    '{K_RESUME,  32'hFFFF_FFFF, 32'd0, 5'd0, 0, '{default: '0}},
    '{K_WAKE,    32'd0, 32'd7, 5'd0, 0, '{default: '0}},
    '{K_SUSPEND, 32'd0, 32'd0, 5'd0, 0, '{default: '0}},
    '{K_RESUME,  32'd0, 32'd0, 5'd0, 0, '{default: '0}},
    '{K_YIELD,   32'd0, 32'd0, 5'd0, 0, '{default: '0}},
    '{K_EXIT,    32'd0, 32'd0, 5'd0, 0, '{default: '0}}
  };

  initial begin
    #20ms;
    $display("[priority_thread_scheduler] ERROR");
    $finish;
  end

  initial begin
    bit quiet;
    for (int k = 0; k < NSLOT; k++) begin
      m_used[k] = 0;
      m_status[k] = ST_FREE;
      m_prio[k] = '0;
      m_thread[k] = '0;
      m_queue[k] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    apb_check({AddrBootPrio, 2'b00}, {27'd0, BootPrioReset}, 32'h1F);
    set_boot(32'hFFFF_FFFF, 5'd31);
    foreach (directed_rows[i]) issue(directed_rows[i], 1'b0);
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: set_boot(32'd0, 5'd0);
        1: set_boot($urandom(), 5'($urandom_range(0, 31)));
        2: set_boot(32'hFFFF_FFFF, 5'd31);
        default: set_boot(32'hA5A5_5A5A, 5'd16);
      endcase
      for (int i = 0; i < 500; i++) begin
        quiet = (i % 100) >= 80;
        issue(random_event(), quiet);
      end
    end
    drain();
    repeat (3 * NSLOT + 20) @(posedge clk_i);
    $display("covered %0d requests, %0d results checked, five boot register settings",
      n_requests, n_results);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[priority_thread_scheduler] OK");
    end else begin
      $display("[priority_thread_scheduler] ERROR");
    end
    $finish;
  end
endmodule
